// ===== src/sct_pkg.sv =====
`timescale 1ns / 1ps

package sct_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam int MODE_W       = 2;
    localparam int MARGIN_W     = 9;
    localparam int MARGIN_SHIFT = 10;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 9'd1;
    localparam logic [MARGIN_W+1:0] MARGIN_SCALE = 11'd1024;
    localparam int HIT_W        = 8;

    // control that travels with one border through the test pipeline
    typedef struct packed {
        logic valid;   // border lies below the fill count
        logic last;    // final border of the scan
        logic live;    // slot occupied by a scan step
    } t_tag;

endpackage

// ===== src/sct_cell.sv =====
`timescale 1ns / 1ps

module sct_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_shift,
    input  logic                    i_load,
    input  logic [4*COORD_BITS-1:0] i_load_seg,
    input  logic [4*COORD_BITS-1:0] i_prev,
    output logic [4*COORD_BITS-1:0] o_seg
);

    logic [4*COORD_BITS-1:0] r_seg;
    logic [4*COORD_BITS-1:0] n_seg;

    // rotate during a scan, take a new border on a load aimed here
    always_comb begin
        n_seg = r_seg;
        if (i_shift) begin
            n_seg = i_prev;
        end else if (i_load) begin
            n_seg = i_load_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign o_seg = r_seg;

endmodule

// ===== src/sct_cross.sv =====
`timescale 1ns / 1ps

module sct_cross #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [COORD_BITS-1:0]         i_ax,
    input  logic signed [COORD_BITS-1:0]         i_ay,
    input  logic signed [COORD_BITS:0]           i_dx,
    input  logic signed [COORD_BITS:0]           i_dy,
    input  logic [sct_pkg::MARGIN_W-1:0]         i_margin,
    input  logic [4*COORD_BITS-1:0]              i_seg,
    input  sct_pkg::t_tag                        i_tag,
    input  logic [IDX_W-1:0]                     i_idx,
    output sct_pkg::t_tag                        o_tag,
    output logic [IDX_W-1:0]                     o_idx,
    output logic                                 o_cross
);

    localparam int C = COORD_BITS;
    localparam int D = C + 1;
    localparam int P = 2 * D;
    localparam int S = P + 1;
    localparam int W = S + 12;

    logic signed [C-1:0] px, py, qx, qy;
    assign px = i_seg[4*C-1:3*C];
    assign py = i_seg[3*C-1:2*C];
    assign qx = i_seg[2*C-1:C];
    assign qy = i_seg[C-1:0];

    sct_pkg::t_tag r_t1, r_t2, r_t3, r_t4, r_t5;
    logic [IDX_W-1:0] r_i1, r_i2, r_i3, r_i4, r_i5;

    // stage 1: differences
    logic signed [D-1:0] r_pax, r_pay, r_qax, r_qay, r_ex, r_ey;
    // stage 2: products
    logic signed [P-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7;
    // stage 3: cross sums
    logic signed [S-1:0] r_num, r_den;
    logic                r_side3, r_side4, r_side5;
    // stage 4: den made non-negative
    logic signed [S-1:0] r_nn, r_dd;
    // stage 5: scaled bounds
    logic signed [W-1:0] r_lo, r_hi, r_n10;

    logic signed [S-1:0] sp, sq;
    logic signed [11:0]  mg;
    logic signed [11:0]  mk;

    assign sp = S'(r_m0) - S'(r_m1);
    assign sq = S'(r_m2) - S'(r_m3);
    assign mg = 12'($signed({1'b0, i_margin}));
    assign mk = $signed({1'b0, sct_pkg::MARGIN_SCALE}) - mg;

    always_ff @(posedge i_clk) begin
        r_pax <= D'(px) - D'(i_ax);
        r_pay <= D'(py) - D'(i_ay);
        r_qax <= D'(qx) - D'(i_ax);
        r_qay <= D'(qy) - D'(i_ay);
        r_ex  <= D'(qx) - D'(px);
        r_ey  <= D'(qy) - D'(py);
        r_i1  <= i_idx;

        r_m0 <= P'(i_dx) * P'(r_pay);
        r_m1 <= P'(i_dy) * P'(r_pax);
        r_m2 <= P'(i_dx) * P'(r_qay);
        r_m3 <= P'(i_dy) * P'(r_qax);
        r_m4 <= P'(r_pax) * P'(r_ey);
        r_m5 <= P'(r_pay) * P'(r_ex);
        r_m6 <= P'(i_dx) * P'(r_ey);
        r_m7 <= P'(i_dy) * P'(r_ex);
        r_i2 <= r_i1;

        r_num   <= S'(r_m4) - S'(r_m5);
        r_den   <= S'(r_m6) - S'(r_m7);
        r_side3 <= (sp < 0 && sq > 0) || (sp > 0 && sq < 0);
        r_i3    <= r_i2;

        r_nn    <= (r_den < 0) ? -r_num : r_num;
        r_dd    <= (r_den < 0) ? -r_den : r_den;
        r_side4 <= r_side3;
        r_i4    <= r_i3;

        r_lo    <= W'(mg) * W'(r_dd);
        r_hi    <= W'(mk) * W'(r_dd);
        r_n10   <= W'(r_nn) <<< sct_pkg::MARGIN_SHIFT;
        r_side5 <= r_side4;
        r_i5    <= r_i4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
            r_t5 <= '0;
        end else begin
            r_t1 <= i_tag;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            r_t5 <= r_t4;
        end
    end

    assign o_tag   = r_t5;
    assign o_idx   = r_i5;
    assign o_cross = r_t5.valid && r_side5 && (r_lo < r_n10) && (r_n10 < r_hi);

endmodule

// ===== src/segment_crossing_test.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// command   in         start && !busy            i_mode, i_start_x/y, i_end_x/y
// result    out        o_done (one-cycle strobe) o_blocked, o_hit_index,
//                                                o_degenerate, o_table_full
// config    in         i_cfg_valid && o_cfg_ready i_cfg_data (edge_margin)
//
// clear and load finish at the transfer; a load or a zero-length query gives its
// result in the cycle after the transfer and busy stays low
// a query scans the border ring once: a full rotation of the ring, one
// border into the crossing pipeline per cycle, then the pipeline drains;
// busy is high from the cycle after the transfer until the result
// synchronous active-low reset empties the table and sets edge_margin to 1
// the result side has no back-pressure; results are never held

module segment_crossing_test #(
    parameter int MAX_BORDERS = 256,
    parameter int COORD_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sct_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sct_pkg::MARGIN_W-1:0]        i_cfg_data,
    output logic                                o_done,
    output logic                                o_blocked,
    output logic [sct_pkg::HIT_W-1:0]           o_hit_index,
    output logic                                o_degenerate,
    output logic                                o_table_full
);

    localparam int C     = COORD_BITS;
    localparam int D     = C + 1;
    localparam int IDX_W = (MAX_BORDERS > 1) ? $clog2(MAX_BORDERS) : 1;
    localparam int CNT_W = $clog2(MAX_BORDERS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BORDERS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BORDERS - 1);

    // command transfer and decode
    logic accept;
    logic do_clear, do_load, do_query;
    assign accept   = start && !busy;
    assign do_clear = accept && (i_mode == sct_pkg::MODE_CLEAR);
    assign do_load  = accept && (i_mode == sct_pkg::MODE_LOAD);
    assign do_query = accept && (i_mode == sct_pkg::MODE_QUERY);

    logic signed [D-1:0] qdx, qdy;
    logic                degen;
    logic                full;
    assign qdx   = D'(i_end_x) - D'(i_start_x);
    assign qdy   = D'(i_end_y) - D'(i_start_y);
    assign degen = (qdx == '0) && (qdy == '0);

    // control registers
    logic                          r_busy, n_busy;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_iss, n_iss;
    logic                          r_hit, n_hit;
    logic [IDX_W-1:0]              r_hit_idx, n_hit_idx;
    logic [sct_pkg::MARGIN_W-1:0]  r_margin;
    // query geometry, held through the scan
    logic signed [C-1:0]           r_ax, r_ay;
    logic signed [D-1:0]           r_dx, r_dy;
    // result registers
    logic                          r_done, n_done;
    logic                          r_blocked, n_blocked;
    logic [IDX_W-1:0]              r_res_idx, n_res_idx;
    logic                          r_degen, n_degen;
    logic                          r_full, n_full;

    assign full  = (r_count >= CNT_MAX);

    // border ring: cell k hands its border to cell k-1, cell 0 wraps to the end
    logic [4*C-1:0] seg_q [MAX_BORDERS];
    logic [4*C-1:0] load_seg;
    logic           scanning;

    assign load_seg = {i_start_x, i_start_y, i_end_x, i_end_y};
    assign scanning = r_busy && (r_iss < CNT_MAX);

    for (genvar k = 0; k < MAX_BORDERS; k++) begin : g_cell
        localparam int NXT = (k + 1) % MAX_BORDERS;
        sct_cell #(
            .COORD_BITS (C)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (scanning),
            .i_load     (do_load && !full && (r_count == CNT_W'(k))),
            .i_load_seg (load_seg),
            .i_prev     (seg_q[NXT]),
            .o_seg      (seg_q[k])
        );
    end

    // cell 0 feeds the crossing pipeline, border r_iss in scan step r_iss
    sct_pkg::t_tag    iss_tag, res_tag;
    logic [IDX_W-1:0] res_idx;
    logic             res_cross;

    assign iss_tag.live  = scanning;
    assign iss_tag.valid = scanning && (r_iss < r_count);
    assign iss_tag.last  = scanning && (r_iss == CNT_LAST);

    sct_cross #(
        .COORD_BITS (C),
        .IDX_W      (IDX_W)
    ) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ax     (r_ax),
        .i_ay     (r_ay),
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .i_margin (r_margin),
        .i_seg    (seg_q[0]),
        .i_tag    (iss_tag),
        .i_idx    (r_iss[IDX_W-1:0]),
        .o_tag    (res_tag),
        .o_idx    (res_idx),
        .o_cross  (res_cross)
    );

    always_comb begin
        n_busy    = r_busy;
        n_count   = r_count;
        n_iss     = r_iss;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_done    = 1'b0;
        n_blocked = 1'b0;
        n_res_idx = '0;
        n_degen   = 1'b0;
        n_full    = 1'b0;

        if (do_clear) begin
            n_count = '0;
        end
        if (do_load) begin
            n_done = 1'b1;
            if (full) begin
                n_full = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
        if (do_query) begin
            if (degen) begin
                n_done  = 1'b1;
                n_degen = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_iss  = '0;
                n_hit  = 1'b0;
            end
        end

        if (scanning) begin
            n_iss = r_iss + 1'b1;
        end

        // first crossing in index order wins
        if (res_tag.live && res_cross && !r_hit) begin
            n_hit     = 1'b1;
            n_hit_idx = res_idx;
        end
        if (res_tag.live && res_tag.last) begin
            n_busy    = 1'b0;
            n_done    = 1'b1;
            n_blocked = r_hit || res_cross;
            n_res_idx = r_hit ? r_hit_idx : (res_cross ? res_idx : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_iss    <= '0;
            r_hit    <= 1'b0;
            r_done   <= 1'b0;
            r_margin <= sct_pkg::MARGIN_RESET;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
            r_iss   <= n_iss;
            r_hit   <= n_hit;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hit_idx <= n_hit_idx;
        r_blocked <= n_blocked;
        r_res_idx <= n_res_idx;
        r_degen   <= n_degen;
        r_full    <= n_full;
        if (do_query) begin
            r_ax <= i_start_x;
            r_ay <= i_start_y;
            r_dx <= qdx;
            r_dy <= qdy;
        end
    end

    // hit index carries the low bits of the border index
    logic [sct_pkg::HIT_W+IDX_W-1:0] hit_ext;
    assign hit_ext = {{sct_pkg::HIT_W{1'b0}}, r_res_idx};

    assign busy         = r_busy;
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_blocked    = r_blocked;
    assign o_hit_index  = hit_ext[sct_pkg::HIT_W-1:0];
    assign o_degenerate = r_degen;
    assign o_table_full = r_full;

endmodule

// ===== src/sct_check.sv =====
`timescale 1ns / 1ps

module sct_check #(
    parameter int MAX_BORDERS = 256,
    parameter int COORD_BITS  = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [sct_pkg::MODE_W-1:0]    i_mode,
    input logic                          o_done,
    input logic                          o_blocked,
    input logic [sct_pkg::HIT_W-1:0]     o_hit_index,
    input logic                          o_degenerate,
    input logic                          o_table_full
);

    // a load transfer answers in the next cycle with a plain load result
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == sct_pkg::MODE_LOAD
        |=> o_done && !o_blocked && !o_degenerate && !busy)
        else $error("load result missing or malformed");

    // a query either starts a scan or answers at once as degenerate
    a_query_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == sct_pkg::MODE_QUERY
        |=> busy || (o_done && o_degenerate && !o_table_full))
        else $error("query neither scanning nor degenerate");

    // no result leaves while a scan is running
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result during scan");

    // an unblocked result reports index zero
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_blocked |-> o_hit_index == '0)
        else $error("hit index without hit");

    // a scan ends with a query result as busy falls
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done && !o_degenerate && !o_table_full)
        else $error("scan ended without query result");

endmodule

bind segment_crossing_test sct_check #(
    .MAX_BORDERS (MAX_BORDERS),
    .COORD_BITS  (COORD_BITS)
) u_sct_check (.*);

// ===== tb/segment_crossing_test_tb.sv =====
`timescale 1ns / 1ps

module testbench;
    import sct_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int TARGET_ITEMS = 1800;
    localparam int SETTLE       = 300;   // one full query scan plus pipeline

    typedef logic signed [15:0] coord_t;

    typedef struct {
        logic             blocked;
        logic [HIT_W-1:0] hit_index;
        logic             degenerate;
        logic             table_full;
    } crossing_result_t;

    // predicts the crossing results and holds them until the block answers
    class crossing_scoreboard;
        longint           bpx[TABLE_DEPTH];
        longint           bpy[TABLE_DEPTH];
        longint           bqx[TABLE_DEPTH];
        longint           bqy[TABLE_DEPTH];
        int               fill;
        longint           margin;
        crossing_result_t awaiting[$];
        int               errors;
        int               n_query, n_hit, n_load, n_drop, n_degen;

        function void reset_state();
            fill   = 0;
            margin = MARGIN_RESET;
            awaiting.delete();
        endfunction

        function void set_margin(logic [MARGIN_W-1:0] m);
            margin = m;
        endfunction

        function int pending();
            return awaiting.size();
        endfunction

        function void queue_result(crossing_result_t r);
            awaiting = {awaiting, r};
        endfunction

        // strict side test, then eps < t < 1 - eps by cross-multiplication
        function bit border_crosses(int k, longint ax, longint ay, longint dx, longint dy);
            longint sp, sq, ex, ey, num, den, lo, hi;
            sp = dx * (bpy[k] - ay) - dy * (bpx[k] - ax);
            sq = dx * (bqy[k] - ay) - dy * (bqx[k] - ax);
            if (!((sp < 0 && sq > 0) || (sp > 0 && sq < 0)))
                return 0;
            ex  = bqx[k] - bpx[k];
            ey  = bqy[k] - bpy[k];
            num = (bpx[k] - ax) * ey - (bpy[k] - ay) * ex;
            den = dx * ey - dy * ex;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            num = num * 1024;
            lo  = margin * den;
            hi  = (1024 - margin) * den;
            return (lo < num) && (num < hi);
        endfunction

        function void note_item(logic [1:0] mode, coord_t sx, coord_t sy, coord_t ex,
                                coord_t ey);
            crossing_result_t r;
            longint dx, dy;
            r = '{1'b0, '0, 1'b0, 1'b0};
            case (mode)
                MODE_CLEAR: begin
                    fill = 0;
                end
                MODE_LOAD: begin
                    n_load++;
                    if (fill >= TABLE_DEPTH) begin
                        r.table_full = 1'b1;
                        n_drop++;
                    end else begin
                        bpx[fill] = sx;
                        bpy[fill] = sy;
                        bqx[fill] = ex;
                        bqy[fill] = ey;
                        fill++;
                    end
                    queue_result(r);
                end
                MODE_QUERY: begin
                    n_query++;
                    dx = longint'(ex) - longint'(sx);
                    dy = longint'(ey) - longint'(sy);
                    if (dx == 0 && dy == 0) begin
                        r.degenerate = 1'b1;
                        n_degen++;
                    end else begin
                        for (int k = 0; k < fill; k++) begin
                            if (border_crosses(k, sx, sy, dx, dy)) begin
                                r.blocked   = 1'b1;
                                r.hit_index = k[HIT_W-1:0];
                                n_hit++;
                                break;
                            end
                        end
                    end
                    queue_result(r);
                end
                default: ;   // unused mode, ignored by the block
            endcase
        endfunction

        function void check_result(crossing_result_t got);
            crossing_result_t want;
            if (awaiting.size() == 0) begin
                $display("%0t: unexpected result blocked=%0b hit=%0d degen=%0b full=%0b",
                         $time, got.blocked, got.hit_index, got.degenerate, got.table_full);
                errors++;
                return;
            end
            want = awaiting.pop_front();
            if (got.blocked !== want.blocked) begin
                $display("%0t: blocked expected %0b actual %0b", $time, want.blocked,
                         got.blocked);
                errors++;
            end
            if (got.hit_index !== want.hit_index) begin
                $display("%0t: hit_index expected %0d actual %0d", $time, want.hit_index,
                         got.hit_index);
                errors++;
            end
            if (got.degenerate !== want.degenerate) begin
                $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                         got.degenerate);
                errors++;
            end
            if (got.table_full !== want.table_full) begin
                $display("%0t: table_full expected %0b actual %0b", $time, want.table_full,
                         got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_W-1:0]    i_mode;
    coord_t               i_start_x, i_start_y, i_end_x, i_end_y;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [MARGIN_W-1:0]  i_cfg_data;
    logic                 o_done;
    logic                 o_blocked;
    logic [HIT_W-1:0]     o_hit_index;
    logic                 o_degenerate;
    logic                 o_table_full;

    crossing_scoreboard sb;
    int  cycle_count;
    int  items_sent;
    bit  gaps_on;

    segment_crossing_test dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_blocked    (o_blocked),
        .o_hit_index  (o_hit_index),
        .o_degenerate (o_degenerate),
        .o_table_full (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor: note each accepted command before checking this edge's result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_item(i_mode, i_start_x, i_start_y, i_end_x, i_end_y);
            if (o_done)
                sb.check_result('{o_blocked, o_hit_index, o_degenerate, o_table_full});
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one command transfer; called at a falling edge, returns at a falling edge
    task automatic send_item(logic [1:0] mode, coord_t sx, coord_t sy, coord_t ex,
                             coord_t ey);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 12)
                @(negedge i_clk);
        end
        start     = 1'b1;
        i_mode    = mode;
        i_start_x = sx;
        i_start_y = sy;
        i_end_x   = ex;
        i_end_y   = ey;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
        if (mode != 2'd3)
            items_sent++;
    endtask

    // let every result come back, then give a clear time to finish too
    task automatic drain();
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_margin(logic [MARGIN_W-1:0] m);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_margin(m);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // narrow coordinates stay within -2048 to 2047 so borders and queries meet
    function automatic coord_t pick_coord(bit narrow);
        if (narrow)
            return coord_t'(int'($urandom_range(0, 4095)) - 2048);
        return coord_t'($urandom);
    endfunction

    task automatic random_query(bit narrow);
        coord_t ax, ay;
        ax = pick_coord(narrow);
        ay = pick_coord(narrow);
        if ($urandom_range(0, 39) == 0)
            send_item(MODE_QUERY, ax, ay, ax, ay);   // zero length
        else
            send_item(MODE_QUERY, ax, ay, pick_coord(narrow), pick_coord(narrow));
    endtask

    task automatic random_load(bit narrow);
        send_item(MODE_LOAD, pick_coord(narrow), pick_coord(narrow), pick_coord(narrow),
                  pick_coord(narrow));
    endtask

    initial begin
        int phase;
        int n_loads, n_queries;
        sb = new();
        sb.reset_state();
        sb.errors = 0;
        cycle_count = 0;
        items_sent  = 0;
        gaps_on     = 1'b1;
        start       = 1'b0;
        i_mode      = MODE_CLEAR;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: default margin of 1/1024 on a horizontal query of 1024 units
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);      // empty table
        send_item(MODE_QUERY, 16'sd77, -16'sd5, 16'sd77, -16'sd5);    // zero length
        send_item(MODE_LOAD, 16'sd1, -16'sd5, 16'sd1, 16'sd5);         // t exactly eps
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);
        send_item(MODE_LOAD, 16'sd100, 16'sd0, 16'sd200, 16'sd9);      // endpoint on line
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);
        send_item(MODE_LOAD, 16'sd2, -16'sd5, 16'sd2, 16'sd5);         // just inside
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);
        send_item(MODE_QUERY, 16'sd1024, 16'sd0, 16'sd0, 16'sd0);      // reversed
        send_item(MODE_LOAD, 16'sd1023, 16'sd5, 16'sd1023, -16'sd5);  // t = 1 - eps
        send_item(2'd3, -16'sd1, -16'sd1, -16'sd1, -16'sd1);           // unused mode
        send_item(MODE_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);      // cleared
        // full-scale diagonals
        send_item(MODE_LOAD, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_item(MODE_QUERY, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_item(MODE_QUERY, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_item(MODE_QUERY, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_item(MODE_CLEAR, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

        // margin extremes on a simple cross
        write_margin(9'd0);
        send_item(MODE_LOAD, 16'sd0, -16'sd5, 16'sd0, 16'sd5);         // through A
        send_item(MODE_LOAD, 16'sd512, -16'sd5, 16'sd512, 16'sd5);     // midpoint
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);
        write_margin(9'd511);
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1024, 16'sd0);
        send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd1000, 16'sd0);      // outside window

        // random phases: clear, fill, then query against the table
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (phase)
                0: write_margin(9'd1);
                1: write_margin(9'd0);
                2: write_margin(9'd511);
                default: begin
                    if ($urandom_range(0, 2) == 0)
                        write_margin(MARGIN_W'($urandom_range(0, 511)));
                end
            endcase
            // one long stretch without command gaps
            gaps_on = !(phase >= 6 && phase < 12);
            send_item(MODE_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0),
                      pick_coord(0));
            if (phase % 6 == 3)
                n_loads = $urandom_range(250, 270);   // may reach the full table
            else
                n_loads = $urandom_range(1, 40);
            n_queries = $urandom_range(15, 45);
            for (int k = 0; k < n_loads; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(2'd3, pick_coord(0), pick_coord(0), pick_coord(0),
                              pick_coord(0));
                random_load($urandom_range(0, 9) != 0);
            end
            for (int k = 0; k < n_queries; k++) begin
                case ($urandom_range(0, 19))
                    0: random_load(1'b0);
                    1: send_item(2'd3, pick_coord(0), pick_coord(0), pick_coord(0),
                                 pick_coord(0));
                    2: random_query(1'b0);
                    default: random_query(1'b1);
                endcase
            end
            phase++;
        end

        drain();
        repeat (SETTLE) @(negedge i_clk);
        $display("covered %0d commands: %0d loads (%0d dropped on a full table)",
                 items_sent, sb.n_load, sb.n_drop);
        $display("%0d queries, %0d blocked, %0d zero length, margins incl. 0 and 511",
                 sb.n_query, sb.n_hit, sb.n_degen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== segment_crossing_test.f =====
src/sct_pkg.sv
src/sct_cell.sv
src/sct_cross.sv
src/segment_crossing_test.sv
src/sct_check.sv
tb/segment_crossing_test_tb.sv
